FILE: design/lcdp_pkg.sv
// shared types and constants for the lcd command sentence parser
// holds transfer payload structs, parse state and character codes
// no dependencies
package lcdp_pkg;

  // sizing of the glyph store
  localparam int GLYPH_SLOTS    = 8;
  localparam int ROWS_PER_GLYPH = 8;
  localparam int COLS_PER_ROW   = 5;

  localparam int SLOT_W    = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int ROW_CNT_W = $clog2(ROWS_PER_GLYPH) + 1;

  // character codes
  localparam logic [7:0] CH_BANG      = 8'h21;  // '!'
  localparam logic [7:0] CH_QUERY     = 8'h3f;  // '?'
  localparam logic [7:0] CH_M         = 8'h4d;  // 'M'
  localparam logic [7:0] CH_C         = 8'h43;  // 'C'
  localparam logic [7:0] CH_COLON     = 8'h3a;  // ':'
  localparam logic [7:0] CH_COMMA     = 8'h2c;  // ','
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_ZERO      = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_TILDE     = 8'h7e;
  localparam int         RADIX        = 10;

  typedef enum logic [1:0] {
    KIND_ROW    = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_BAD  = 2'd1,
    STATUS_ECHO = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_ECHO,
    PH_ITEMS,
    PH_M_COLON,
    PH_MSG_FIRST,
    PH_MSG_TEXT,
    PH_MSG_ESC,
    PH_MSG_NUM,
    PH_C_NUM,
    PH_ROW_WS,
    PH_ROW_NUM,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       is_end;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] glyph_index;
    logic [2:0] row_index;
    logic [4:0] row_bits;
    logic [7:0] message_byte;
    status_t    status;
  } result_t;

  typedef struct packed {
    phase_t                 phase;
    logic [GLYPH_SLOTS-1:0] defined_mask;
    logic [SLOT_W-1:0]      current_slot;
    logic [ROW_CNT_W-1:0]   row_counter;
    logic [7:0]             accumulator;
    logic                   digit_seen;
    logic                   number_overflow;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:           PH_START,
    defined_mask:    '0,
    current_slot:    '0,
    row_counter:     '0,
    accumulator:     8'd0,
    digit_seen:      1'b0,
    number_overflow: 1'b0
  };

endpackage

FILE: design/lcdp_step.sv
// next-state and result logic for one sentence character
// purely combinational, sits between the item register and the result register
// depends on lcdp_pkg
module lcdp_step
  import lcdp_pkg::*;
(
  input  item_t        item,
  input  parse_state_t state,
  output parse_state_t state_next,
  output logic         emit,
  output result_t      res
);

  localparam int MASK_EXT_W = 2 ** SLOT_W;

  logic [7:0]            c;
  logic                  c_ws;
  logic                  c_digit;
  logic                  c_print;
  logic [3:0]            digit;
  logic [11:0]           acc_sum;
  logic [7:0]            acc_add;
  logic                  ovf_add;
  logic                  num_clean;
  logic                  slot_ok;
  logic                  row_ok;
  logic [MASK_EXT_W-1:0] mask_ext;
  logic                  mask_bit;
  logic                  escape_ok;
  logic [ROW_CNT_W-1:0]  rc_inc;
  logic [MASK_EXT_W-1:0] slot_one;

  assign c       = item.symbol;
  assign c_ws    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign c_print = (c >= CH_SPACE) && (c <= CH_TILDE);
  assign digit   = 4'(c - CH_ZERO);

  // accumulate one decimal digit, times ten as shift and add
  assign acc_sum = 12'(({4'd0, state.accumulator} << 3) + ({4'd0, state.accumulator} << 1))
                 + 12'(digit);
  assign acc_add = acc_sum[7:0];
  assign ovf_add = state.number_overflow || (acc_sum > 12'd255);

  assign num_clean = state.digit_seen && !state.number_overflow;
  assign slot_ok   = num_clean && ({1'b0, state.accumulator} < 9'(GLYPH_SLOTS));
  assign row_ok    = num_clean && ({1'b0, state.accumulator} < 9'(2 ** COLS_PER_ROW));

  assign mask_ext  = MASK_EXT_W'(state.defined_mask);
  assign mask_bit  = slot_ok && mask_ext[state.accumulator[SLOT_W-1:0]];
  assign escape_ok = slot_ok && mask_bit;

  assign rc_inc   = state.row_counter + ROW_CNT_W'(1);
  assign slot_one = MASK_EXT_W'(1) << state.current_slot;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    res        = '{kind: KIND_ROW, status: STATUS_OK, default: '0};

    if (item.is_end) begin
      res.kind = KIND_STATUS;
      unique case (state.phase)
        PH_ECHO:                 res.status = STATUS_ECHO;
        PH_MSG_TEXT, PH_MSG_ESC: res.status = STATUS_OK;
        PH_MSG_NUM:              res.status = escape_ok ? STATUS_OK : STATUS_BAD;
        default:                 res.status = STATUS_BAD;
      endcase
      emit       = 1'b1;
      state_next = STATE_RESET;
    end else begin
      unique case (state.phase)
        PH_START: begin
          if (c == CH_BANG) begin
            state_next.phase = PH_ITEMS;
          end else if (c == CH_QUERY) begin
            state_next.phase = PH_ECHO;
          end else if (!c_ws) begin
            state_next.phase = PH_ERROR;
          end
        end
        PH_ECHO: begin
          if (!c_ws) begin
            state_next.phase = PH_ERROR;
          end
        end
        PH_ITEMS: begin
          if (c == CH_M) begin
            state_next.phase = PH_M_COLON;
          end else if (c == CH_C) begin
            state_next.accumulator     = 8'd0;
            state_next.digit_seen      = 1'b0;
            state_next.number_overflow = 1'b0;
            state_next.phase           = PH_C_NUM;
          end
        end
        PH_M_COLON: begin
          state_next.phase = (c == CH_COLON) ? PH_MSG_FIRST : PH_ERROR;
        end
        PH_MSG_FIRST, PH_MSG_TEXT, PH_MSG_ESC, PH_MSG_NUM: begin
          if ((state.phase == PH_MSG_ESC) && c_digit) begin
            // first digit of an escape number
            state_next.accumulator     = {4'd0, digit};
            state_next.digit_seen      = 1'b1;
            state_next.number_overflow = 1'b0;
            state_next.phase           = PH_MSG_NUM;
            emit                       = 1'b1;
          end else if ((state.phase == PH_MSG_NUM) && c_digit) begin
            state_next.accumulator     = acc_add;
            state_next.digit_seen      = 1'b1;
            state_next.number_overflow = ovf_add;
            emit                       = 1'b1;
          end else if ((state.phase == PH_MSG_NUM) && !escape_ok) begin
            state_next.phase = PH_ERROR;
          end else if (!c_print) begin
            state_next.phase = PH_ERROR;
          end else begin
            state_next.phase = (c == CH_BACKSLASH) ? PH_MSG_ESC : PH_MSG_TEXT;
            emit             = 1'b1;
          end
          if (emit) begin
            res.kind         = KIND_BYTE;
            res.message_byte = c;
          end
        end
        PH_C_NUM: begin
          if (c_digit) begin
            state_next.accumulator     = acc_add;
            state_next.digit_seen      = 1'b1;
            state_next.number_overflow = ovf_add;
          end else if (!slot_ok || mask_bit || (c != CH_COLON)) begin
            state_next.phase = PH_ERROR;
          end else begin
            state_next.current_slot = state.accumulator[SLOT_W-1:0];
            state_next.row_counter  = '0;
            state_next.phase        = PH_ROW_WS;
          end
        end
        PH_ROW_WS: begin
          if (c_digit) begin
            state_next.accumulator     = {4'd0, digit};
            state_next.digit_seen      = 1'b1;
            state_next.number_overflow = 1'b0;
            state_next.phase           = PH_ROW_NUM;
          end else if (!c_ws) begin
            state_next.phase = PH_ERROR;
          end
        end
        PH_ROW_NUM: begin
          if (c_digit) begin
            state_next.accumulator     = acc_add;
            state_next.digit_seen      = 1'b1;
            state_next.number_overflow = ovf_add;
          end else if (!row_ok || (c != CH_COMMA)) begin
            state_next.phase = PH_ERROR;
          end else begin
            emit            = 1'b1;
            res.kind        = KIND_ROW;
            res.glyph_index = 3'(state.current_slot);
            res.row_index   = 3'(state.row_counter);
            res.row_bits    = state.accumulator[4:0];
            if (rc_inc >= ROW_CNT_W'(ROWS_PER_GLYPH)) begin
              // last row closes the glyph definition
              state_next.defined_mask = state.defined_mask | GLYPH_SLOTS'(slot_one);
              state_next.row_counter  = '0;
              state_next.phase        = PH_ITEMS;
            end else begin
              state_next.row_counter = rc_inc;
              state_next.phase       = PH_ROW_WS;
            end
          end
        end
        default: begin
          state_next.phase = PH_ERROR;
        end
      endcase
    end
  end

endmodule

FILE: design/lcd_command_sentence_parser.sv
// top level of the lcd command sentence parser
// item register, parse state, result register and checks
// depends on lcdp_pkg and lcdp_step
//
// usage
//   item channel: item carries one sentence character (symbol) or, with
//   is_end set, the end of the sentence; a transfer happens at a rising
//   edge with item_valid high and item_stall low
//   result channel: result carries a glyph row, a raw message byte or the
//   final sentence status; transfer on result_valid high, result_stall low
//   path: a result passes through the item register at its transfer and
//   then the result register, which a stalled result can hold; items
//   that cause no result simply update the parse state
//   throughput: one item per cycle unless a stalled result blocks it, set
//   by updating the parse state from item register into result register
//   stall: a stalled result holds in the result register while the item
//   register still takes one more item; item_stall rises only when both
//   are full, and follows result_stall in the same cycle
//   reset: rst is synchronous and active high; it empties both registers
//   and returns the parse state to sentence start with no glyphs defined
module lcd_command_sentence_parser
  import lcdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // item register
  logic  s1_valid;
  item_t s1_item;

  // parse state
  parse_state_t state;
  parse_state_t state_next;

  logic    step_emit;
  result_t step_res;
  logic    advance;

  // the item register moves on whenever the result register can take a value
  assign advance    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;

  lcdp_step u_step (
    .item       (s1_item),
    .state      (state),
    .state_next (state_next),
    .emit       (step_emit),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step_emit;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) begin
      result <= step_res;
    end
  end

  // an end of sentence always yields a status result
  a_end_gives_status: assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.is_end |=> result_valid && (result.kind == KIND_STATUS))
    else $error("end of sentence without status result");

  // an end of sentence clears the parse state
  a_end_clears_state: assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.is_end |=> (state.phase == PH_START) && (state.defined_mask == '0))
    else $error("parse state not cleared after end of sentence");

  // only printable bytes leave as message bytes
  a_byte_printable: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == KIND_BYTE) |->
      (result.message_byte >= CH_SPACE) && (result.message_byte <= CH_TILDE))
    else $error("non-printable message byte emitted");

  // input back-pressure only while the item register is full and blocked
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid && result_stall)
    else $error("item stall without a blocked pipeline");

endmodule

FILE: dv/tb_lcd_command_sentence_parser.sv
// self-checking testbench for the lcd command sentence parser
// predicts rows, message bytes and sentence status in a small tracker class
// depends on lcdp_pkg and the lcd_command_sentence_parser rtl
module tb_lcd_command_sentence_parser;
  import lcdp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int DRAIN_CYCLES   = 8;

  // mirrors the parse state and queues the results the parser owes us
  class sentence_tracker;
    result_t                pending_outputs[$];
    int unsigned            errors;
    phase_t                 phase;
    logic [GLYPH_SLOTS-1:0] defined;
    logic [SLOT_W-1:0]      slot;
    int                     row;
    logic [7:0]             acc;
    bit                     seen;
    bit                     overflow;

    function new();
      errors = 0;
      clear_sentence();
    endfunction

    function void start_number();
      acc      = '0;
      seen     = 1'b0;
      overflow = 1'b0;
    endfunction

    function void clear_sentence();
      phase   = PH_START;
      defined = '0;
      slot    = '0;
      row     = 0;
      start_number();
    endfunction

    function void add_digit(logic [7:0] c);
      int v;
      v    = int'(acc) * RADIX + int'(c - CH_ZERO);
      seen = 1'b1;
      if (v > 255) overflow = 1'b1;
      acc = v[7:0];
    endfunction

    function bit number_fits(int bound);
      return seen && !overflow && int'(acc) < bound;
    endfunction

    function bit escape_names_glyph();
      if (!number_fits(GLYPH_SLOTS)) return 1'b0;
      return defined[acc[SLOT_W-1:0]];
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void emit_byte(logic [7:0] c);
      result_t r;
      r              = '0;
      r.kind         = KIND_BYTE;
      r.message_byte = c;
      pending_outputs.push_back(r);
    endfunction

    // plain message character: printable bytes go out raw, anything else spoils the sentence
    function void message_char(logic [7:0] c);
      if (c < CH_SPACE || c > CH_TILDE) begin
        phase = PH_ERROR;
      end else begin
        phase = (c == CH_BACKSLASH) ? PH_MSG_ESC : PH_MSG_TEXT;
        emit_byte(c);
      end
    endfunction

    function void parse_item(item_t it);
      result_t    r;
      logic [7:0] c;
      c = it.symbol;
      r = '0;
      if (it.is_end) begin
        r.kind   = KIND_STATUS;
        r.status = STATUS_BAD;
        case (phase)
          PH_ECHO:                 r.status = STATUS_ECHO;
          PH_MSG_TEXT, PH_MSG_ESC: r.status = STATUS_OK;
          PH_MSG_NUM:              if (escape_names_glyph()) r.status = STATUS_OK;
          default: ;
        endcase
        pending_outputs.push_back(r);
        clear_sentence();
        return;
      end
      case (phase)
        PH_START: begin
          if (c == CH_BANG) phase = PH_ITEMS;
          else if (c == CH_QUERY) phase = PH_ECHO;
          else if (!is_space(c)) phase = PH_ERROR;
        end
        PH_ECHO: if (!is_space(c)) phase = PH_ERROR;
        PH_ITEMS: begin
          // stray letters between items are skipped
          if (c == CH_M) begin
            phase = PH_M_COLON;
          end else if (c == CH_C) begin
            start_number();
            phase = PH_C_NUM;
          end
        end
        PH_M_COLON: phase = (c == CH_COLON) ? PH_MSG_FIRST : PH_ERROR;
        PH_MSG_FIRST, PH_MSG_TEXT: message_char(c);
        PH_MSG_ESC: begin
          if (is_digit(c)) begin
            start_number();
            add_digit(c);
            phase = PH_MSG_NUM;
            emit_byte(c);
          end else begin
            message_char(c);
          end
        end
        PH_MSG_NUM: begin
          // the character after an escape number is checked, not swallowed
          if (is_digit(c)) begin
            add_digit(c);
            emit_byte(c);
          end else if (!escape_names_glyph()) begin
            phase = PH_ERROR;
          end else begin
            message_char(c);
          end
        end
        PH_C_NUM: begin
          if (is_digit(c)) begin
            add_digit(c);
          end else if (!number_fits(GLYPH_SLOTS) || defined[acc[SLOT_W-1:0]]
                       || c != CH_COLON) begin
            phase = PH_ERROR;
          end else begin
            slot  = acc[SLOT_W-1:0];
            row   = 0;
            phase = PH_ROW_WS;
          end
        end
        PH_ROW_WS: begin
          if (is_digit(c)) begin
            start_number();
            add_digit(c);
            phase = PH_ROW_NUM;
          end else if (!is_space(c)) begin
            phase = PH_ERROR;
          end
        end
        PH_ROW_NUM: begin
          if (is_digit(c)) begin
            add_digit(c);
          end else if (!number_fits(1 << COLS_PER_ROW) || c != CH_COMMA) begin
            phase = PH_ERROR;
          end else begin
            r.kind        = KIND_ROW;
            r.glyph_index = slot;
            r.row_index   = row[2:0];
            r.row_bits    = acc[4:0];
            pending_outputs.push_back(r);
            row++;
            if (row >= ROWS_PER_GLYPH) begin
              defined[slot] = 1'b1;
              row           = 0;
              phase         = PH_ITEMS;
            end else begin
              phase = PH_ROW_WS;
            end
          end
        end
        default: phase = PH_ERROR;
      endcase
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void compare_output(result_t got);
      result_t want;
      if (pending_outputs.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, got);
        errors++;
        return;
      end
      want = pending_outputs.pop_front();
      compare_field("kind", int'(want.kind), int'(got.kind));
      compare_field("glyph_index", want.glyph_index, got.glyph_index);
      compare_field("row_index", want.row_index, got.row_index);
      compare_field("row_bits", want.row_bits, got.row_bits);
      compare_field("message_byte", want.message_byte, got.message_byte);
      compare_field("status", int'(want.status), int'(got.status));
    endfunction
  endclass

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  sentence_tracker tracker = new();

  int unsigned quiet_cycles = 0;
  int          burst_left   = 0;
  int          sent_items   = 0;
  logic [7:0]  text_q[$];

  // receiver stall pattern
  int stall_mode = 0;
  int mode_left  = 0;
  int run_left   = 0;

  lcd_command_sentence_parser dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: quiet stretches, scattered stalls, and long on/off runs
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(40, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          result_stall <= ~result_stall;
          run_left     <= $urandom_range(1, 8);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  // both channels are sampled on the edge that completes a transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) tracker.parse_item(item);
      if (result_valid && !result_stall) tracker.compare_output(result);
      quiet_cycles <= ((item_valid && !item_stall) || (result_valid && !result_stall)) ?
                      0 : quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("lcd_command_sentence_parser test failed");
    $finish;
  end

  // one item per call; a gap opens whenever the current burst runs out
  task automatic send_item(input logic [7:0] sym, input logic last);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    item_valid <= 1'b1;
    item       <= '{symbol: sym, is_end: last};
    do @(posedge clk); while (item_stall);
    burst_left--;
    sent_items++;
  endtask

  task automatic send_sentence();
    foreach (text_q[i]) send_item(text_q[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    text_q.delete();
  endtask

  function automatic void put_char(logic [7:0] c);
    text_q.push_back(c);
  endfunction

  function automatic void put_string(string s);
    foreach (s[i]) put_char(s[i]);
  endfunction

  function automatic void put_space();
    repeat ($urandom_range(0, 2))
      put_char($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
  endfunction

  // decimal text, now and then with a leading zero
  function automatic void put_number(int v);
    if ($urandom_range(0, 7) == 0) put_char(CH_ZERO);
    put_string($sformatf("%0d", v));
  endfunction

  function automatic void put_message_head();
    put_char(CH_BANG);
    put_char(CH_M);
    put_char(CH_COLON);
  endfunction

  // mostly well-formed command with random content, with the odd fault worked in
  function automatic void build_command();
    logic [7:0] used;
    int         slot;
    int         len;
    used = '0;
    put_space();
    put_char(CH_BANG);
    repeat ($urandom_range(0, 3)) begin
      put_space();
      if ($urandom_range(0, 9) == 0) put_char(8'($urandom_range(8'h61, 8'h7a)));
      put_char(CH_C);
      slot = $urandom_range(0, 7);
      if ($urandom_range(0, 5) != 0)
        repeat (GLYPH_SLOTS) if (used[slot]) slot = (slot + 1) % GLYPH_SLOTS;
      if ($urandom_range(0, 19) == 0) slot = $urandom_range(GLYPH_SLOTS, 400);
      put_number(slot);
      put_char(CH_COLON);
      if (slot < GLYPH_SLOTS) used[slot] = 1'b1;
      repeat (ROWS_PER_GLYPH) begin
        put_space();
        put_number(($urandom_range(0, 39) == 0) ? $urandom_range(32, 999) : $urandom_range(0, 31));
        put_char(CH_COMMA);
      end
    end
    put_space();
    put_char(CH_M);
    put_char(CH_COLON);
    len = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
    repeat (len) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // escape, usually naming a glyph that exists
          put_char(CH_BACKSLASH);
          slot = $urandom_range(0, 7);
          repeat (GLYPH_SLOTS) if (!used[slot]) slot = (slot + 1) % GLYPH_SLOTS;
          if ($urandom_range(0, 5) == 0) slot = $urandom_range(0, 300);
          put_number(slot);
        end
        2: begin
          if ($urandom_range(0, 5) == 0)
            put_char($urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255)));
          else
            put_char(8'($urandom_range(CH_SPACE, CH_TILDE)));
        end
        default: put_char(8'($urandom_range(CH_SPACE, CH_TILDE)));
      endcase
    end
    if ($urandom_range(0, 12) == 0) text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
  endfunction

  initial begin
    int goal;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // echo query, empty sentence
    put_char(CH_QUERY);
    send_sentence();
    send_sentence();
    // printable extremes in a message
    put_message_head();
    put_char(CH_SPACE);
    put_char(CH_TILDE);
    send_sentence();
    // empty message
    put_message_head();
    send_sentence();
    // unknown lead character
    put_string("x");
    send_sentence();
    // non-printable message bytes at both ends of the code range
    put_message_head();
    put_char(8'h01);
    send_sentence();
    put_message_head();
    put_char(8'hff);
    send_sentence();
    // bare escape closing the sentence
    put_message_head();
    put_char(CH_BACKSLASH);
    send_sentence();

    goal = sent_items + RANDOM_ITEMS;
    while (sent_items < goal) begin
      case ($urandom_range(0, 9))
        0: begin
          put_space();
          put_char(CH_QUERY);
          put_space();
          if ($urandom_range(0, 4) == 0) put_char(8'($urandom));
        end
        1, 2: repeat ($urandom_range(0, 10)) put_char(8'($urandom));
        default: build_command();
      endcase
      send_sentence();
    end
    item_valid <= 1'b0;

    @(posedge clk);
    while (tracker.pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("lcd_command_sentence_parser test passed");
    else
      $display("lcd_command_sentence_parser test failed");
    $finish;
  end

endmodule

FILE: files.f
design/lcdp_pkg.sv
design/lcdp_step.sv
design/lcd_command_sentence_parser.sv
dv/tb_lcd_command_sentence_parser.sv
